// ===== sv/ccfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Control character frame deframer package
// Byte codes, event kinds, front phases and the request record that goes
// from the front to the back through the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfd_pkg;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam int PID_W = 31;
	localparam int PID_CHARS_W = 4;
	localparam int CMD_CNT_W = 7;
	localparam logic [PID_W-1:0] PID_LIMIT = 31'h7FFF_FFFF;

	typedef enum logic [1:0] {
		EV_DATA = 2'd0,
		EV_ACK = 2'd1,
		EV_EOT = 2'd2
	} event_kind_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_PID = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_REPLAY = 1'b1
	} back_state_t;

	typedef struct packed {
		event_kind_t kind;
		logic [PID_W-1:0] pid;
		logic [CMD_CNT_W-1:0] cnt;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/control_char_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Control character frame deframer
// Hunts for SOH, parses a decimal PID and closes the frame on ACK, EOT or
// STX data ETX. Control frames give one event; data frames are replayed
// byte by byte with the last byte marked. Malformed frames are dropped.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   rx       | rx_valid, rx_stall  | rx_byte
//   evt      | evt_valid, evt_stall| event_kind, frame_pid, payload_byte, last
//
// A received byte is taken every cycle while no data frame is being replayed
// and the request queue is not full. After ETX of a data frame the front
// stalls until the back has loaded the last byte, one byte per cycle when evt
// is not stalled; the single payload memory port pair sets this.
// ACK and EOT events pass through a two-entry request queue and stall the
// front only while that queue is full.
// Reset is asynchronous; the payload memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module control_char_frame_deframer #(
	parameter int DATA_DEPTH = 64,
	parameter int PID_MAX_CHARS = 15
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rx_valid,
	output logic rx_stall,
	input wire logic [7:0] rx_byte,
	output logic evt_valid,
	input wire logic evt_stall,
	output logic [1:0] event_kind,
	output logic [ccfd_pkg::PID_W-1:0] frame_pid,
	output logic [7:0] payload_byte,
	output logic last
);
	import ccfd_pkg::*;

	localparam int AW = $clog2(DATA_DEPTH);

	logic q_full;
	logic q_empty;
	logic push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t q_head;
	logic replay_done;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;

	ccfd_front #(
		.DATA_DEPTH(DATA_DEPTH),
		.PID_MAX_CHARS(PID_MAX_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.rx_byte(rx_byte),
		.q_full(q_full),
		.push(push),
		.cmd(push_cmd),
		.replay_done(replay_done),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	ccfd_cmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.empty(q_empty),
		.head(q_head)
	);

	ccfd_back #(
		.DATA_DEPTH(DATA_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.replay_done(replay_done),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.event_kind(event_kind),
		.frame_pid(frame_pid),
		.payload_byte(payload_byte),
		.last(last)
	);

endmodule

`default_nettype wire

// ===== sv/ccfd_front.sv =====
// ----------------------------------------------------------------------------
// Deframer front
// Accepts received bytes, tracks the frame phase, parses the PID, stores
// data bytes and posts one request per finished frame that is not dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfd_front #(
	parameter int DATA_DEPTH = 64,
	parameter int PID_MAX_CHARS = 15,
	localparam int AW = $clog2(DATA_DEPTH),
	localparam int CW = $clog2(DATA_DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rx_valid,
	output logic rx_stall,
	input wire logic [7:0] rx_byte,
	input wire logic q_full,
	output logic push,
	output ccfd_pkg::cmd_t cmd,
	input wire logic replay_done,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0] wr_data
);
	import ccfd_pkg::*;

	phase_t phase_q, phase_d;
	logic [PID_W-1:0] pid_q;
	logic [PID_CHARS_W-1:0] chars_q;
	logic digits_done_q;
	logic ovf_q;
	logic [CW-1:0] count_q;
	logic busy_q;

	logic acc;
	logic start_frame;
	logic to_data;
	logic take_char;
	logic is_digit;
	logic chars_full;
	logic count_full;
	logic [PID_W+3:0] pid_next;

	assign rx_stall = busy_q || q_full;
	assign acc = rx_valid && !rx_stall;
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign chars_full = chars_q >= PID_CHARS_W'(PID_MAX_CHARS);
	assign count_full = count_q >= CW'(DATA_DEPTH);
	assign pid_next = ({4'd0, pid_q} << 3) + ({4'd0, pid_q} << 1)
		+ {{PID_W{1'b0}}, rx_byte[3:0]};

	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			unique case (phase_q)
				PH_PID: begin
					if (rx_byte == CH_ACK || rx_byte == CH_EOT) begin
						phase_d = PH_HUNT;
					end else if (rx_byte == CH_STX) begin
						phase_d = PH_DATA;
					end else if (rx_byte == CH_SOH) begin
						phase_d = PH_PID;
					end else if (chars_full) begin
						phase_d = PH_HUNT;
					end
				end
				PH_DATA: begin
					if (rx_byte == CH_ETX || rx_byte == CH_STX || count_full) begin
						phase_d = PH_HUNT;
					end
				end
				default: begin
					phase_d = (rx_byte == CH_SOH) ? PH_PID : PH_HUNT;
				end
			endcase
		end
	end

	always_comb begin
		push = 1'b0;
		cmd = '{kind: EV_DATA, pid: pid_q, cnt: '0};
		wr_en = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = rx_byte;
		start_frame = 1'b0;
		to_data = 1'b0;
		take_char = 1'b0;
		if (acc) begin
			unique case (phase_q)
				PH_PID: begin
					if (rx_byte == CH_ACK || rx_byte == CH_EOT) begin
						push = !ovf_q;
						cmd.kind = (rx_byte == CH_ACK) ? EV_ACK : EV_EOT;
					end else if (rx_byte == CH_STX) begin
						to_data = 1'b1;
					end else if (rx_byte == CH_SOH) begin
						start_frame = 1'b1;
					end else if (!chars_full) begin
						take_char = 1'b1;
					end
				end
				PH_DATA: begin
					if (rx_byte == CH_ETX) begin
						push = !ovf_q && (count_q != '0);
						cmd.cnt = CMD_CNT_W'(count_q);
					end else if (rx_byte != CH_STX && !count_full) begin
						wr_en = 1'b1;
					end
				end
				default: begin
					start_frame = (rx_byte == CH_SOH);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pid_q <= '0;
			chars_q <= '0;
			digits_done_q <= 1'b0;
			ovf_q <= 1'b0;
			count_q <= '0;
			busy_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (push && cmd.kind == EV_DATA) begin
				busy_q <= 1'b1;
			end else if (replay_done) begin
				busy_q <= 1'b0;
			end
			if (start_frame) begin
				pid_q <= '0;
				chars_q <= '0;
				digits_done_q <= 1'b0;
				ovf_q <= 1'b0;
				count_q <= '0;
			end else begin
				if (to_data) begin
					count_q <= '0;
				end else if (wr_en) begin
					count_q <= count_q + 1'b1;
				end
				if (take_char) begin
					chars_q <= chars_q + 1'b1;
					if (!digits_done_q) begin
						if (!is_digit) begin
							digits_done_q <= 1'b1;
						end else if (!ovf_q) begin
							if (pid_next > {4'd0, PID_LIMIT}) begin
								ovf_q <= 1'b1;
								pid_q <= PID_LIMIT;
							end else begin
								pid_q <= pid_next[PID_W-1:0];
							end
						end
					end
				end
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("request pushed into a full queue");
	a_write_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> phase_q == PH_DATA) else $error("payload write outside data phase");
	a_busy_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.kind == EV_DATA) |=> busy_q && rx_stall)
		else $error("front not held after data frame request");

endmodule

`default_nettype wire

// ===== sv/ccfd_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Deframer request queue
// Two-entry queue of frame requests between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfd_cmd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire ccfd_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic empty,
	output ccfd_pkg::cmd_t head
);
	import ccfd_pkg::*;

	cmd_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overrun");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underrun");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue fill count out of range");

endmodule

`default_nettype wire

// ===== sv/ccfd_back.sv =====
// ----------------------------------------------------------------------------
// Deframer back
// Holds the payload memory, takes frame requests from the queue and sends
// events, replaying a data frame one byte per cycle while evt is not
// stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfd_back #(
	parameter int DATA_DEPTH = 64,
	localparam int AW = $clog2(DATA_DEPTH),
	localparam int CW = $clog2(DATA_DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_empty,
	input wire ccfd_pkg::cmd_t q_head,
	output logic q_pop,
	output logic replay_done,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [7:0] wr_data,
	output logic evt_valid,
	input wire logic evt_stall,
	output logic [1:0] event_kind,
	output logic [ccfd_pkg::PID_W-1:0] frame_pid,
	output logic [7:0] payload_byte,
	output logic last
);
	import ccfd_pkg::*;

	back_state_t state_q, state_d;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [PID_W-1:0] pid_q;
	logic [7:0] rd_data_q;
	logic [7:0] mem [DATA_DEPTH];

	logic out_valid_q;
	event_kind_t kind_q;
	logic [PID_W-1:0] out_pid_q;
	logic [7:0] byte_q;
	logic last_q;

	logic out_free;
	logic is_last;
	logic load_evt;
	logic load_byte;
	logic [AW-1:0] rd_addr;

	assign out_free = !out_valid_q || !evt_stall;
	assign is_last = (CW'(idx_q) + 1'b1) == cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free && q_head.kind == EV_DATA) begin
					state_d = BK_REPLAY;
				end
			end
			BK_REPLAY: begin
				if (out_free && is_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop = 1'b0;
		load_evt = 1'b0;
		load_byte = 1'b0;
		rd_addr = idx_q;
		unique case (state_q)
			BK_IDLE: begin
				q_pop = !q_empty && out_free;
				load_evt = q_pop && q_head.kind != EV_DATA;
				rd_addr = '0;
			end
			BK_REPLAY: begin
				load_byte = out_free;
				rd_addr = out_free ? idx_q + 1'b1 : idx_q;
			end
			default: ;
		endcase
		replay_done = load_byte && is_last;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cnt_q <= q_head.cnt[CW-1:0];
			pid_q <= q_head.pid;
		end
		if (load_evt) begin
			kind_q <= q_head.kind;
			out_pid_q <= q_head.pid;
			byte_q <= '0;
			last_q <= 1'b1;
		end else if (load_byte) begin
			kind_q <= EV_DATA;
			out_pid_q <= pid_q;
			byte_q <= rd_data_q;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				idx_q <= '0;
			end else if (load_byte) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_evt || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign evt_valid = out_valid_q;
	assign event_kind = kind_q;
	assign frame_pid = out_pid_q;
	assign payload_byte = byte_q;
	assign last = last_q;

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_REPLAY |-> CW'(idx_q) < cnt_q) else $error("replay index past frame");
	a_done_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		replay_done |=> out_valid_q && last_q && kind_q == EV_DATA)
		else $error("replay end without last byte");
	a_pop_nonempty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_head.kind == EV_DATA) |-> q_head.cnt != '0)
		else $error("empty data frame requested");

endmodule

`default_nettype wire
